@@ rtl/core/ptt_pkg.sv @@
// Shared types, constants and helpers for the periodic timer table.
// No dependencies; every other file in rtl/core imports this package.
`timescale 1ns / 1ps
package ptt_pkg;

    localparam int MAX_TASKS = 16;
    localparam int IDX_W     = $clog2(MAX_TASKS);
    localparam int CNT_W     = $clog2(MAX_TASKS + 1);
    localparam int NOW_W     = 48;
    localparam int DUE_W     = 49;
    localparam int PER_W     = 32;
    localparam int ID_W      = 16;
    localparam int RUN_W     = 16;

    localparam logic [2:0] CMD_TICK   = 3'd0;
    localparam logic [2:0] CMD_SCHED  = 3'd1;
    localparam logic [2:0] CMD_RSET   = 3'd2;
    localparam logic [2:0] CMD_RADD   = 3'd3;
    localparam logic [2:0] CMD_RESET  = 3'd4;
    localparam logic [2:0] CMD_CANCEL = 3'd5;
    localparam logic [2:0] CMD_QUERY  = 3'd6;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_ZERO_RUNS = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_NEG_PER   = 3'd4;

    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_FIRE   = 1'b1;

    typedef struct packed {
        logic [2:0]               command;
        logic [ID_W-1:0]          task_id;
        logic signed [PER_W-1:0]  period_ms;
        logic signed [RUN_W-1:0]  run_count;
    } t_item;

    typedef struct packed {
        logic            result_kind;
        logic [ID_W-1:0] result_id;
        logic [2:0]      status;
        logic            is_scheduled;
        logic            last;
    } t_result;

    typedef struct packed {
        logic [ID_W-1:0]          ident;
        logic signed [PER_W-1:0]  period;
        logic signed [PER_W-1:0]  order_period;
        logic signed [DUE_W-1:0]  due;
        logic signed [RUN_W-1:0]  runs;
    } t_entry;

    function automatic t_result mk_res(input logic kind, input logic [ID_W-1:0] id,
                                       input logic [2:0] st, input logic sched,
                                       input logic last);
        t_result r;
        r.result_kind  = kind;
        r.result_id    = id;
        r.status       = st;
        r.is_scheduled = sched;
        r.last         = last;
        return r;
    endfunction

    function automatic logic signed [DUE_W-1:0] sext_per(input logic signed [PER_W-1:0] p);
        return {{(DUE_W-PER_W){p[PER_W-1]}}, p};
    endfunction

endpackage

@@ rtl/core/ptt_alu.sv @@
// Shared due-time adder with saturation to the signed due range.
// Depends on ptt_pkg.
`timescale 1ns / 1ps
module ptt_alu
    import ptt_pkg::*;
(
    input  logic signed [DUE_W-1:0] i_a,
    input  logic signed [DUE_W-1:0] i_b,
    output logic signed [DUE_W:0]   o_sum,
    output logic signed [DUE_W-1:0] o_sat
);
    assign o_sum = {i_a[DUE_W-1], i_a} + {i_b[DUE_W-1], i_b};

    // Overflow shows as a disagreement of the two top bits.
    always_comb begin
        if (o_sum[DUE_W] != o_sum[DUE_W-1]) begin
            o_sat = o_sum[DUE_W] ? {1'b1, {(DUE_W-1){1'b0}}} : {1'b0, {(DUE_W-1){1'b1}}};
        end else begin
            o_sat = o_sum[DUE_W-1:0];
        end
    end
endmodule

@@ rtl/core/ptt_table.sv @@
// Timer entry store: valid flags cleared at reset, payload written on demand.
// One read port, one full write port and one valid-clear port. Depends on ptt_pkg.
`timescale 1ns / 1ps
module ptt_table
    import ptt_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [IDX_W-1:0] i_rd_idx,
    output logic             o_rd_vld,
    output t_entry           o_rd_entry,
    input  logic             i_wr_en,
    input  logic [IDX_W-1:0] i_wr_idx,
    input  t_entry           i_wr_entry,
    input  logic             i_clr_en,
    input  logic [IDX_W-1:0] i_clr_idx
);
    logic   r_vld [MAX_TASKS];
    t_entry r_ent [MAX_TASKS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_TASKS; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else begin
            if (i_clr_en) begin
                r_vld[i_clr_idx] <= 1'b0;
            end
            if (i_wr_en) begin
                r_vld[i_wr_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_ent[i_wr_idx] <= i_wr_entry;
        end
    end

    assign o_rd_vld   = r_vld[i_rd_idx];
    assign o_rd_entry = r_ent[i_rd_idx];
endmodule

@@ rtl/core/periodic_timer_table.sv @@
// Top level of the periodic timer table: command sequencer, time base and result register.
// Depends on ptt_pkg, ptt_alu and ptt_table.
`timescale 1ns / 1ps
//
// Channel   Direction  Handshake                  Payload
// command   in         start high, busy low       i_item  (t_item)
// result    out        o_res_valid, one cycle     o_res   (t_result)
//
// Every command walks the table one entry per cycle through a single read port.
// Schedule, reschedule, reset, cancel and query take one search pass (a request
// with zero runs is refused at once); a query, a missing id or a full table
// answers at the end of that pass, the others go on to the update or insert states.
// A schedule first shifts the entries behind its slot, and a cancel adds a
// compaction pass. A tick makes a pass to mark due entries, then a firing step
// and a search pass per firing plus a final search, then a compaction pass.
// Reset is synchronous; it clears the time base and all valid flags and sets the
// id counter to one. The receiver cannot stall: each result beat is shown for
// exactly one cycle, and busy stays high until the command is fully handled.
module periodic_timer_table
    import ptt_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    input  t_item   i_item,
    output logic    o_res_valid,
    output t_result o_res
);
    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_ELIG    = 9'b000000010,
        S_SCAN    = 9'b000000100,
        S_FIRE    = 9'b000001000,
        S_FIND    = 9'b000010000,
        S_SHIFT   = 9'b000100000,
        S_INS     = 9'b001000000,
        S_UPD     = 9'b010000000,
        S_UPD2    = 9'b100000000
    } t_state;

    // Compaction reuses the search walk; a flag tells it apart.
    t_state                  r_state, n_state;
    logic                    r_cmp, n_cmp;
    t_item                   r_item, n_item;
    logic [NOW_W-1:0]        r_now, n_now;
    logic [ID_W-1:0]         r_idc, n_idc;
    logic [IDX_W-1:0]        r_ptr, n_ptr;
    logic [IDX_W-1:0]        r_best, n_best;
    logic                    r_found, n_found;
    logic signed [DUE_W-1:0] r_best_due, n_best_due;
    logic [MAX_TASKS-1:0]    r_elig, n_elig;
    logic                    r_pend_vld, n_pend_vld;
    logic [ID_W-1:0]         r_pend_id, n_pend_id;
    logic                    r_pend_stay, n_pend_stay;
    logic [CNT_W-1:0]        r_cnt, n_cnt;
    logic [CNT_W-1:0]        r_pos, n_pos;
    logic                    r_posdone, n_posdone;
    logic                    r_hit, n_hit;
    logic [IDX_W-1:0]        r_hit_idx, n_hit_idx;
    logic [CNT_W-1:0]        r_j, n_j;
    logic [IDX_W-1:0]        r_w, n_w;
    logic signed [PER_W-1:0] r_np, n_np;
    logic                    r_out_vld, n_out_vld;
    t_result                 r_out, n_out;

    logic [IDX_W-1:0]        rd_idx;
    logic                    rd_vld;
    t_entry                  rd_ent;
    logic                    wr_en;
    logic [IDX_W-1:0]        wr_idx;
    t_entry                  wr_ent;
    logic                    clr_en;
    logic [IDX_W-1:0]        clr_idx;
    logic signed [DUE_W-1:0] alu_a, alu_b;
    logic signed [DUE_W:0]   alu_sum;
    logic signed [DUE_W-1:0] alu_sat;

    logic signed [DUE_W-1:0] now_s;
    logic                    walk_end;
    logic                    cand;
    logic signed [RUN_W-1:0] runs_new;
    logic [CNT_W-1:0]        j_m1;

    ptt_table u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_idx   (rd_idx),
        .o_rd_vld   (rd_vld),
        .o_rd_entry (rd_ent),
        .i_wr_en    (wr_en),
        .i_wr_idx   (wr_idx),
        .i_wr_entry (wr_ent),
        .i_clr_en   (clr_en),
        .i_clr_idx  (clr_idx)
    );

    ptt_alu u_alu (
        .i_a   (alu_a),
        .i_b   (alu_b),
        .o_sum (alu_sum),
        .o_sat (alu_sat)
    );

    assign now_s    = $signed({1'b0, r_now});
    assign walk_end = (r_ptr == IDX_W'(MAX_TASKS - 1));
    assign j_m1     = r_j - CNT_W'(1);

    always_comb begin
        n_state     = r_state;
        n_cmp       = r_cmp;
        n_item      = r_item;
        n_now       = r_now;
        n_idc       = r_idc;
        n_ptr       = r_ptr;
        n_best      = r_best;
        n_found     = r_found;
        n_best_due  = r_best_due;
        n_elig      = r_elig;
        n_pend_vld  = r_pend_vld;
        n_pend_id   = r_pend_id;
        n_pend_stay = r_pend_stay;
        n_cnt       = r_cnt;
        n_pos       = r_pos;
        n_posdone   = r_posdone;
        n_hit       = r_hit;
        n_hit_idx   = r_hit_idx;
        n_j         = r_j;
        n_w         = r_w;
        n_np        = r_np;
        n_out_vld   = 1'b0;
        n_out       = r_out;
        rd_idx      = r_ptr;
        wr_en       = 1'b0;
        wr_idx      = r_ptr;
        wr_ent      = rd_ent;
        clr_en      = 1'b0;
        clr_idx     = r_ptr;
        alu_a       = rd_ent.due;
        alu_b       = sext_per(rd_ent.period);
        cand        = 1'b0;
        runs_new    = rd_ent.runs;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_item    = i_item;
                    n_ptr     = '0;
                    n_cnt     = '0;
                    n_pos     = '0;
                    n_posdone = 1'b0;
                    n_hit     = 1'b0;
                    n_cmp     = 1'b0;
                    unique case (i_item.command) inside
                        CMD_TICK: begin
                            n_now   = r_now + NOW_W'(1);
                            n_state = S_ELIG;
                        end
                        CMD_SCHED: begin
                            if (i_item.run_count == '0) begin
                                n_out_vld = 1'b1;
                                n_out = mk_res(KIND_STATUS, '0, ST_ZERO_RUNS, 1'b0, 1'b1);
                            end else begin
                                n_state = S_FIND;
                            end
                        end
                        CMD_RSET, CMD_RADD: begin
                            if (i_item.run_count == '0) begin
                                n_out_vld = 1'b1;
                                n_out = mk_res(KIND_STATUS, i_item.task_id, ST_ZERO_RUNS,
                                               1'b0, 1'b1);
                            end else begin
                                n_state = S_FIND;
                            end
                        end
                        CMD_RESET, CMD_CANCEL, CMD_QUERY: begin
                            n_state = S_FIND;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            // Mark the entries that are due at the new time.
            S_ELIG: begin
                n_elig[r_ptr] = rd_vld && (rd_ent.due <= now_s);
                n_ptr = r_ptr + IDX_W'(1);
                if (walk_end) begin
                    n_found = 1'b0;
                    n_state = S_SCAN;
                end
            end

            // Find the earliest due eligible entry; the first in list order wins ties.
            S_SCAN: begin
                cand = r_elig[r_ptr] && (!r_found || (rd_ent.due < r_best_due));
                if (cand) begin
                    n_found    = 1'b1;
                    n_best     = r_ptr;
                    n_best_due = rd_ent.due;
                end
                n_ptr = r_ptr + IDX_W'(1);
                if (walk_end) begin
                    if (r_found || cand) begin
                        n_state = S_FIRE;
                    end else begin
                        if (r_pend_vld) begin
                            n_out_vld = 1'b1;
                            n_out = mk_res(KIND_FIRE, r_pend_id, ST_OK, r_pend_stay, 1'b1);
                        end
                        n_pend_vld = 1'b0;
                        n_w        = '0;
                        n_cmp      = 1'b1;
                        n_state    = S_FIND;
                    end
                end
            end

            // Fire one entry. Its beat is held back one round so that the
            // final firing can carry the last mark.
            S_FIRE: begin
                rd_idx = r_best;
                wr_idx = r_best;
                clr_idx = r_best;
                alu_a = rd_ent.due;
                alu_b = sext_per(rd_ent.period);
                runs_new = (rd_ent.runs > 0) ? rd_ent.runs - RUN_W'(1) : rd_ent.runs;
                wr_ent.runs = runs_new;
                wr_ent.due  = alu_sat;
                if (runs_new != '0) begin
                    wr_en = 1'b1;
                end else begin
                    clr_en = 1'b1;
                end
                n_elig[r_best] = 1'b0;
                if (r_pend_vld) begin
                    n_out_vld = 1'b1;
                    n_out = mk_res(KIND_FIRE, r_pend_id, ST_OK, r_pend_stay, 1'b0);
                end
                n_pend_vld  = 1'b1;
                n_pend_id   = rd_ent.ident;
                n_pend_stay = (runs_new != '0);
                n_ptr   = '0;
                n_found = 1'b0;
                n_state = S_SCAN;
            end

            // Search walk: id lookup, fill count and insertion point, or,
            // with the compaction flag set, squeeze out removed entries.
            S_FIND: begin
                n_ptr = r_ptr + IDX_W'(1);
                if (r_cmp) begin
                    if (rd_vld) begin
                        if (r_w != r_ptr) begin
                            wr_en   = 1'b1;
                            wr_idx  = r_w;
                            clr_en  = 1'b1;
                            clr_idx = r_ptr;
                        end
                        n_w = r_w + IDX_W'(1);
                    end
                    if (walk_end) begin
                        n_cmp   = 1'b0;
                        n_state = S_IDLE;
                    end
                end else begin
                    if (rd_vld) begin
                        n_cnt = r_cnt + CNT_W'(1);
                        if (!r_posdone) begin
                            if (rd_ent.order_period < r_item.period_ms) begin
                                n_pos = CNT_W'(r_ptr) + CNT_W'(1);
                            end else begin
                                n_posdone = 1'b1;
                            end
                        end
                        if (!r_hit && (rd_ent.ident == r_item.task_id)) begin
                            n_hit     = 1'b1;
                            n_hit_idx = r_ptr;
                        end
                    end
                    if (walk_end) begin
                        if (r_item.command == CMD_SCHED) begin
                            if (n_cnt == CNT_W'(MAX_TASKS)) begin
                                n_out_vld = 1'b1;
                                n_out = mk_res(KIND_STATUS, '0, ST_FULL, 1'b0, 1'b1);
                                n_state = S_IDLE;
                            end else begin
                                n_j = n_cnt;
                                n_state = (n_cnt > n_pos) ? S_SHIFT : S_INS;
                            end
                        end else if (r_item.command == CMD_QUERY) begin
                            n_out_vld = 1'b1;
                            n_out = mk_res(KIND_STATUS, r_item.task_id, ST_OK, n_hit, 1'b1);
                            n_state = S_IDLE;
                        end else if (!n_hit) begin
                            n_out_vld = 1'b1;
                            n_out = mk_res(KIND_STATUS, r_item.task_id, ST_NOT_FOUND,
                                           1'b0, 1'b1);
                            n_state = S_IDLE;
                        end else begin
                            n_state = S_UPD;
                        end
                    end
                end
            end

            // Open a slot at the insertion point, one entry per cycle from the end.
            S_SHIFT: begin
                rd_idx = j_m1[IDX_W-1:0];
                wr_en  = 1'b1;
                wr_idx = r_j[IDX_W-1:0];
                n_j    = j_m1;
                if (j_m1 == r_pos) begin
                    n_state = S_INS;
                end
            end

            S_INS: begin
                alu_a = now_s;
                alu_b = sext_per(r_item.period_ms);
                wr_en = 1'b1;
                wr_idx = r_pos[IDX_W-1:0];
                wr_ent.ident        = r_idc;
                wr_ent.period       = r_item.period_ms;
                wr_ent.order_period = r_item.period_ms;
                wr_ent.due          = alu_sat;
                wr_ent.runs         = r_item.run_count;
                n_out_vld = 1'b1;
                n_out = mk_res(KIND_STATUS, r_idc, ST_OK, 1'b0, 1'b1);
                n_idc = r_idc + ID_W'(1);
                n_state = S_IDLE;
            end

            S_UPD: begin
                rd_idx  = r_hit_idx;
                wr_idx  = r_hit_idx;
                clr_idx = r_hit_idx;
                n_state = S_IDLE;
                n_out_vld = 1'b1;
                n_out = mk_res(KIND_STATUS, r_item.task_id, ST_OK, 1'b0, 1'b1);
                unique case (r_item.command)
                    CMD_RSET: begin
                        alu_a = now_s;
                        alu_b = sext_per(r_item.period_ms);
                        if (r_item.period_ms < 0) begin
                            n_out.status = ST_NEG_PER;
                        end else begin
                            wr_en = 1'b1;
                            wr_ent.period = r_item.period_ms;
                            wr_ent.runs   = r_item.run_count;
                            wr_ent.due    = alu_sat;
                        end
                    end
                    CMD_RADD: begin
                        // New period first; the due time moves in the next cycle.
                        alu_a = sext_per(rd_ent.period);
                        alu_b = sext_per(r_item.period_ms);
                        if (alu_sum[DUE_W]) begin
                            n_out.status = ST_NEG_PER;
                        end else begin
                            n_out_vld = 1'b0;
                            n_np = (alu_sum[DUE_W-1:PER_W-1] != '0)
                                 ? {1'b0, {(PER_W-1){1'b1}}} : alu_sum[PER_W-1:0];
                            n_state = S_UPD2;
                        end
                    end
                    CMD_RESET: begin
                        alu_a = now_s;
                        alu_b = sext_per(rd_ent.period);
                        wr_en = 1'b1;
                        wr_ent.due = alu_sat;
                    end
                    default: begin
                        // Cancel: drop the entry and close the gap.
                        clr_en  = 1'b1;
                        n_ptr   = '0;
                        n_w     = '0;
                        n_cmp   = 1'b1;
                        n_state = S_FIND;
                    end
                endcase
            end

            S_UPD2: begin
                rd_idx = r_hit_idx;
                wr_idx = r_hit_idx;
                alu_a  = rd_ent.due;
                alu_b  = sext_per(r_item.period_ms);
                wr_en  = 1'b1;
                wr_ent.period = r_np;
                wr_ent.due    = alu_sat;
                wr_ent.runs   = r_item.run_count;
                n_out_vld = 1'b1;
                n_out = mk_res(KIND_STATUS, r_item.task_id, ST_OK, 1'b0, 1'b1);
                n_state = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cmp      <= 1'b0;
            r_now      <= '0;
            r_idc      <= ID_W'(1);
            r_elig     <= '0;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cmp      <= n_cmp;
            r_now      <= n_now;
            r_idc      <= n_idc;
            r_elig     <= n_elig;
            r_pend_vld <= n_pend_vld;
            r_out_vld  <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item      <= n_item;
        r_ptr       <= n_ptr;
        r_best      <= n_best;
        r_found     <= n_found;
        r_best_due  <= n_best_due;
        r_pend_id   <= n_pend_id;
        r_pend_stay <= n_pend_stay;
        r_cnt       <= n_cnt;
        r_pos       <= n_pos;
        r_posdone   <= n_posdone;
        r_hit       <= n_hit;
        r_hit_idx   <= n_hit_idx;
        r_j         <= n_j;
        r_w         <= n_w;
        r_np        <= n_np;
        r_out       <= n_out;
    end

    assign busy        = (r_state != S_IDLE);
    assign o_res_valid = r_out_vld;
    assign o_res       = r_out;
endmodule

@@ bench/tb_top.sv @@
// Self-checking bench for periodic_timer_table: directed and random command beats,
// checked against an in-bench timer-table predictor. Depends on ptt_pkg and the RTL.
`timescale 1ns / 1ps
module tb_top;
    import ptt_pkg::*;

    localparam longint DUE_HI  = 64'sh0000_FFFF_FFFF_FFFF;
    localparam longint DUE_LO  = -DUE_HI - 1;
    localparam longint PER_TOP = 64'sd2147483647;
    localparam logic [2:0] CMD_UNUSED = 3'd7;

    // Timer-table scoreboard: it mirrors the table, computes the result beats that
    // each accepted command beat should cause and compares the beats that come out.
    class timer_scoreboard;
        logic [NOW_W-1:0] now_ms;
        logic [ID_W-1:0]  next_id;
        bit               used   [MAX_TASKS];
        logic [ID_W-1:0]  ident  [MAX_TASKS];
        longint           period [MAX_TASKS];
        longint           order  [MAX_TASKS];
        longint           due    [MAX_TASKS];
        int               runs   [MAX_TASKS];
        t_result          awaited[$];
        int               errors, n_cmds, n_beats, n_fired;

        function new();
            now_ms  = '0;
            next_id = 16'd1;
            foreach (used[i]) used[i] = 1'b0;
            errors = 0; n_cmds = 0; n_beats = 0; n_fired = 0;
        endfunction

        function longint clamp_due(longint v);
            if (v > DUE_HI) return DUE_HI;
            if (v < DUE_LO) return DUE_LO;
            return v;
        endfunction

        function void move_slot(int dst, int src);
            used[dst] = used[src];   ident[dst] = ident[src];
            period[dst] = period[src]; order[dst] = order[src];
            due[dst] = due[src];     runs[dst] = runs[src];
        endfunction

        // Squeeze out freed slots, keeping list order.
        function void squeeze();
            int w;
            w = 0;
            for (int r = 0; r < MAX_TASKS; r++) begin
                if (used[r]) begin
                    if (w != r) move_slot(w, r);
                    w++;
                end
            end
            for (; w < MAX_TASKS; w++) used[w] = 1'b0;
        endfunction

        function int find_task(logic [ID_W-1:0] id);
            for (int i = 0; i < MAX_TASKS; i++)
                if (used[i] && ident[i] == id) return i;
            return -1;
        endfunction

        // A live id for well-formed traffic, or a random one if the table is empty.
        function logic [ID_W-1:0] live_id();
            int n;
            n = 0;
            while (n < MAX_TASKS && used[n]) n++;
            if (n == 0) return ID_W'($urandom_range(0, 20));
            return ident[$urandom_range(0, n - 1)];
        endfunction

        function void push_status(logic [ID_W-1:0] id, logic [2:0] st, logic sched);
            awaited.push_back(mk_res(KIND_STATUS, id, st, sched, 1'b1));
        endfunction

        function void run_tick();
            bit     elig[MAX_TASKS];
            int     best, fired;
            bit     stays;
            longint now_s;
            now_ms = now_ms + 1'b1;
            now_s  = longint'({16'd0, now_ms});
            for (int i = 0; i < MAX_TASKS; i++) elig[i] = used[i] && due[i] <= now_s;
            fired = 0;
            while (fired < MAX_TASKS) begin
                best = -1;
                for (int i = 0; i < MAX_TASKS; i++)
                    if (elig[i] && (best < 0 || due[i] < due[best])) best = i;
                if (best < 0) break;
                elig[best] = 1'b0;
                if (runs[best] > 0) runs[best]--;
                stays = runs[best] != 0;
                if (stays) due[best] = clamp_due(due[best] + period[best]);
                else used[best] = 1'b0;
                awaited.push_back(mk_res(KIND_FIRE, ident[best], ST_OK, stays, 1'b0));
                fired++;
                n_fired++;
            end
            squeeze();
            // Only the final firing of the tick carries the last flag.
            if (fired > 0) awaited[awaited.size() - 1].last = 1'b1;
        endfunction

        function void run_schedule(longint per, int rc);
            int cnt, pos;
            if (rc == 0) begin
                push_status('0, ST_ZERO_RUNS, 1'b0);
                return;
            end
            cnt = 0;
            while (cnt < MAX_TASKS && used[cnt]) cnt++;
            if (cnt >= MAX_TASKS) begin
                push_status('0, ST_FULL, 1'b0);
                return;
            end
            pos = 0;
            while (pos < cnt && order[pos] < per) pos++;
            for (int j = cnt; j > pos; j--) move_slot(j, j - 1);
            used[pos] = 1'b1;  ident[pos] = next_id;
            period[pos] = per; order[pos] = per;
            due[pos]  = clamp_due(longint'({16'd0, now_ms}) + per);
            runs[pos] = rc;
            push_status(next_id, ST_OK, 1'b0);
            next_id = next_id + 1'b1;
        endfunction

        // Note an accepted command beat and queue the results it should cause.
        function void note_command(t_item it);
            longint per, np;
            int     rc, idx;
            per = longint'(it.period_ms);
            rc  = int'(it.run_count);
            n_cmds++;
            case (it.command)
                CMD_TICK:  run_tick();
                CMD_SCHED: run_schedule(per, rc);
                CMD_UNUSED: ;
                default: begin
                    idx = find_task(it.task_id);
                    if ((it.command == CMD_RSET || it.command == CMD_RADD) && rc == 0)
                        push_status(it.task_id, ST_ZERO_RUNS, 1'b0);
                    else if (it.command == CMD_QUERY)
                        push_status(it.task_id, ST_OK, idx >= 0);
                    else if (idx < 0)
                        push_status(it.task_id, ST_NOT_FOUND, 1'b0);
                    else if (it.command == CMD_RSET) begin
                        if (per < 0) push_status(it.task_id, ST_NEG_PER, 1'b0);
                        else begin
                            period[idx] = per;
                            runs[idx]   = rc;
                            due[idx]    = clamp_due(longint'({16'd0, now_ms}) + per);
                            push_status(it.task_id, ST_OK, 1'b0);
                        end
                    end else if (it.command == CMD_RADD) begin
                        np = period[idx] + per;
                        if (np < 0) push_status(it.task_id, ST_NEG_PER, 1'b0);
                        else begin
                            period[idx] = (np > PER_TOP) ? PER_TOP : np;
                            due[idx]    = clamp_due(due[idx] + per);
                            runs[idx]   = rc;
                            push_status(it.task_id, ST_OK, 1'b0);
                        end
                    end else if (it.command == CMD_RESET) begin
                        due[idx] = clamp_due(longint'({16'd0, now_ms}) + period[idx]);
                        push_status(it.task_id, ST_OK, 1'b0);
                    end else begin
                        used[idx] = 1'b0;
                        squeeze();
                        push_status(it.task_id, ST_OK, 1'b0);
                    end
                end
            endcase
        endfunction

        function void check_result(t_result got);
            t_result exp;
            n_beats++;
            if (awaited.size() == 0) begin
                $error("unexpected result beat kind=%0d id=%0d", got.result_kind,
                       got.result_id);
                errors++;
                return;
            end
            exp = awaited.pop_front();
            if (got.result_kind !== exp.result_kind) begin
                $error("result_kind: expected %0d, got %0d", exp.result_kind, got.result_kind);
                errors++;
            end
            if (got.result_id !== exp.result_id) begin
                $error("result_id: expected %0d, got %0d", exp.result_id, got.result_id);
                errors++;
            end
            if (got.status !== exp.status) begin
                $error("status: expected %0d, got %0d", exp.status, got.status);
                errors++;
            end
            if (got.is_scheduled !== exp.is_scheduled) begin
                $error("is_scheduled: expected %0d, got %0d", exp.is_scheduled,
                       got.is_scheduled);
                errors++;
            end
            if (got.last !== exp.last) begin
                $error("last: expected %0d, got %0d", exp.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic    i_clk = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    start = 1'b0;
    logic    busy;
    t_item   i_item = '0;
    logic    o_res_valid;
    t_result o_res;

    timer_scoreboard sb = new();
    bit              no_gaps;

    periodic_timer_table uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .o_res_valid (o_res_valid),
        .o_res       (o_res)
    );

    always #1 i_clk = ~i_clk;

    // Result beats last one cycle and cannot be held off, so every strobed cycle
    // is checked at the edge that ends it.
    always @(posedge i_clk) begin
        if (i_rst_n && o_res_valid) sb.check_result(o_res);
    end

    // Hand one command beat to the block. An optional idle gap comes first; start
    // stays high straight into the next beat when there is no gap.
    task automatic send_command(t_item it);
        int gap;
        if (no_gaps) gap = 0;
        else if ($urandom_range(0, 9) < 6) gap = 0;
        else if ($urandom_range(0, 9) < 8) gap = $urandom_range(1, 4);
        else gap = $urandom_range(20, 150);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        sb.note_command(it);
    endtask

    task automatic send(logic [2:0] cmd, logic [ID_W-1:0] id, logic [31:0] per,
                        logic [15:0] rc);
        t_item it;
        it.command   = cmd;
        it.task_id   = id;
        it.period_ms = per;
        it.run_count = rc;
        send_command(it);
    endtask

    // Random beat: mostly well-formed traffic on live ids with short periods and
    // plenty of ticks, plus some noise with wide-open fields.
    function automatic t_item random_command();
        t_item it;
        int    pick;
        pick = $urandom_range(0, 99);
        it.task_id   = sb.live_id();
        it.period_ms = $urandom_range(0, 12);
        it.run_count = ($urandom_range(0, 3) == 0) ? 16'hFFFF
                                                    : RUN_W'($urandom_range(1, 4));
        if (pick < 40)      it.command = CMD_TICK;
        else if (pick < 62) it.command = CMD_SCHED;
        else if (pick < 68) it.command = CMD_RSET;
        else if (pick < 74) begin
            it.command   = CMD_RADD;
            it.period_ms = $signed($urandom_range(0, 16)) - 8;
        end
        else if (pick < 79) it.command = CMD_RESET;
        else if (pick < 86) it.command = CMD_CANCEL;
        else if (pick < 92) it.command = CMD_QUERY;
        else begin
            it.command   = 3'($urandom_range(0, 7));
            it.task_id   = ID_W'($urandom);
            it.period_ms = $urandom;
            it.run_count = RUN_W'($urandom);
        end
        return it;
    endfunction

    initial begin
        no_gaps = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: field extremes, every command, and the corner cases.
        send(CMD_SCHED,  16'd0,    32'd5,          16'd0);      // zero runs rejected
        send(CMD_SCHED,  16'd0,    32'hFFFF_FFFF,  16'hFFFF);   // negative period: every tick
        send(CMD_SCHED,  16'd0,    32'h7FFF_FFFF,  16'h7FFF);   // largest period
        send(CMD_SCHED,  16'd0,    32'h8000_0000,  16'd2);      // most negative period
        send(CMD_SCHED,  16'd0,    32'd2,          16'd1);
        send(CMD_TICK,   16'd0,    32'd0,          16'd0);
        send(CMD_TICK,   16'hFFFF, 32'hFFFF_FFFF,  16'hFFFF);
        send(CMD_QUERY,  16'd3,    32'd0,          16'd0);
        send(CMD_QUERY,  16'hFFFF, 32'd0,          16'd0);
        send(CMD_RSET,   16'd3,    32'd1,          16'd0);      // zero runs before lookup
        send(CMD_RSET,   16'hFFFF, 32'd1,          16'd1);      // not found
        send(CMD_RSET,   16'd3,    32'hFFFF_FFF0,  16'd1);      // not found: id 3 has run out
        send(CMD_RSET,   16'd3,    32'd3,          16'd3);
        send(CMD_RADD,   16'd3,    32'h7FFF_FFFF,  16'hFFFF);   // not found: id 3 has run out
        send(CMD_RADD,   16'd3,    32'h8000_0000,  16'd1);      // not found: id 3 has run out
        send(CMD_RADD,   16'd3,    32'hFFFF_FFFF,  16'd4);
        send(CMD_RESET,  16'd3,    32'd0,          16'd0);
        send(CMD_RESET,  16'd999,  32'd0,          16'd0);
        send(CMD_CANCEL, 16'd1,    32'd0,          16'd0);
        send(CMD_CANCEL, 16'd1,    32'd0,          16'd0);
        send(CMD_UNUSED, 16'd1,    32'd0,          16'd0);      // ignored code
        // Fill the table with one-shot timers so that a tick fires many at once,
        // and push one more schedule past capacity.
        for (int k = 0; k < 16; k++) send(CMD_SCHED, 16'd0, 32'd1, 16'd1);
        send(CMD_TICK,   16'd0,    32'd0,          16'd0);

        for (int k = 0; k < 330; k++) begin
            if (k % 40 == 0) no_gaps = ($urandom_range(0, 2) == 0);
            send_command(random_command());
        end
        start <= 1'b0;

        while (sb.awaited.size() != 0) @(posedge i_clk);
        // Trailing ticks may still be scanning without a result to show for it.
        repeat (400) @(posedge i_clk);

        $display("Covered %0d command beats, %0d result beats, %0d timer firings.",
                 sb.n_cmds, sb.n_beats, sb.n_fired);
        if (sb.errors == 0 && sb.awaited.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #3000000;
        $display("simulation failed");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/ptt_pkg.sv
rtl/core/ptt_alu.sv
rtl/core/ptt_table.sv
rtl/core/periodic_timer_table.sv
bench/tb_top.sv
